// ----- hw/rtl/crank_tooth_sync_decoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// Crank tooth sync decoder assertion macros
// Shared property wrappers for the port checker. All sample on clk_i and are
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CRANK_TOOTH_SYNC_DECODER_TOP_MACROS_SVH
`define CRANK_TOOTH_SYNC_DECODER_TOP_MACROS_SVH

// Same-cycle implication.
`define CTSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crank tooth sync decoder: same-cycle check failed");

// Next-cycle implication.
`define CTSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crank tooth sync decoder: next-cycle check failed");

`endif

// ----- hw/rtl/ctsd_pkg.sv -----
// ----------------------------------------------------------------------------
// ctsd_pkg
// Types and constants shared by the crank tooth sync decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsd_pkg;

  localparam logic [7:0]  TEETH_RESET  = 8'd12;
  localparam logic [7:0]  TEETH_MAX    = 8'd255;
  localparam int unsigned HALF_BIT     = 15;

  // Ticks per degree is period / 720. It saturates once the period reaches
  // 65536 * 720; below that, period / 720 = (period >> 4) / 45.
  localparam int unsigned DEG_PER_CYCLE  = 720;
  localparam logic [31:0] TPD_SAT_LIMIT  = 32'(65536 * DEG_PER_CYCLE);
  localparam int unsigned DIV_IN_W       = 22;
  localparam int unsigned RECIP_SHIFT    = 28;
  localparam int unsigned RECIP_W        = 23;
  localparam logic [RECIP_W-1:0] RECIP_M = 23'd5965233;  // ceil(2^28 / 45)
  localparam int unsigned PROD_W         = DIV_IN_W + RECIP_W;

  typedef struct packed {
    logic        in_sync;
    logic [7:0]  tooth_count;
    logic        sample_request;
    logic        sync_lost;
    logic        tooth_dropped;
    logic [31:0] cycle_period;
    logic [15:0] sync_loss_count;
    logic [15:0] dropped_count;
    logic [15:0] primary_edges_seen;
    logic [15:0] secondary_edges_seen;
  } ctsd_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ctsd_core.sv -----
// ----------------------------------------------------------------------------
// ctsd_core
// Decoder state: tooth count, sync flag, reference timestamp, period and the
// event counters. Produces the result of an edge in the cycle it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsd_core import ctsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        accept_i,
  input  wire logic        kind_i,
  input  wire logic        pin_high_i,
  input  wire logic [15:0] edge_time_i,
  input  wire logic [15:0] timer_high_i,
  input  wire logic        overflow_pending_i,
  output ctsd_res_t        res_o
);

  logic [7:0]  tpr_q;
  logic [7:0]  cnt_q, cnt_d, cnt_inc;
  logic        synced_q, synced_d;
  logic [31:0] last_q, last_d;
  logic [31:0] period_q, period_d;
  logic [15:0] losses_q, losses_d;
  logic [15:0] drops_q, drops_d;
  logic [15:0] prim_q, prim_d;
  logic [15:0] sec_q, sec_d;
  logic [15:0] stamp_hi;
  logic [31:0] stamp, interval;
  logic        sample, lost, dropped;

  always_comb begin
    cnt_inc  = (cnt_q == TEETH_MAX) ? cnt_q : cnt_q + 8'd1;
    stamp_hi = timer_high_i + {15'd0, (overflow_pending_i && !edge_time_i[HALF_BIT])};
    stamp    = {stamp_hi, edge_time_i};
    interval = stamp - last_q;

    cnt_d    = cnt_q;
    synced_d = synced_q;
    last_d   = last_q;
    period_d = period_q;
    losses_d = losses_q;
    drops_d  = drops_q;
    prim_d   = prim_q;
    sec_d    = sec_q;
    sample   = 1'b0;
    lost     = 1'b0;
    dropped  = 1'b0;

    if (!kind_i) begin
      if (pin_high_i) begin
        cnt_d = cnt_inc;
        if (!synced_q) begin
          drops_d = drops_q + 16'd1;
          dropped = 1'b1;
        end else if (cnt_inc > tpr_q) begin
          losses_d = losses_q + 16'd1;
          synced_d = 1'b0;
          cnt_d    = 8'd0;
          lost     = 1'b1;
        end else begin
          sample = !cnt_inc[0];
        end
      end
      prim_d = prim_q + 16'd1;
    end else begin
      if (pin_high_i) begin
        // The count is checked against the expected value before it clears.
        if (synced_q && (cnt_q != tpr_q)) begin
          losses_d = losses_q + 16'd1;
          lost     = 1'b1;
        end
        cnt_d    = 8'd0;
        period_d = {interval[30:0], 1'b0};
        last_d   = stamp;
        synced_d = 1'b1;
      end
      sec_d = sec_q + 16'd1;
    end
  end

  always_comb begin
    res_o.in_sync              = synced_d;
    res_o.tooth_count          = cnt_d;
    res_o.sample_request       = sample;
    res_o.sync_lost            = lost;
    res_o.tooth_dropped        = dropped;
    res_o.cycle_period         = period_d;
    res_o.sync_loss_count      = losses_d;
    res_o.dropped_count        = drops_d;
    res_o.primary_edges_seen   = prim_d;
    res_o.secondary_edges_seen = sec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpr_q <= TEETH_RESET;
    end else if (cfg_we_i) begin
      tpr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      synced_q <= 1'b0;
      last_q   <= '0;
      period_q <= '0;
      losses_q <= '0;
      drops_q  <= '0;
      prim_q   <= '0;
      sec_q    <= '0;
    end else if (accept_i) begin
      cnt_q    <= cnt_d;
      synced_q <= synced_d;
      last_q   <= last_d;
      period_q <= period_d;
      losses_q <= losses_d;
      drops_q  <= drops_d;
      prim_q   <= prim_d;
      sec_q    <= sec_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ctsd_tpd.sv -----
// ----------------------------------------------------------------------------
// ctsd_tpd
// Output stage: divides the cycle period by 720 with a reciprocal multiply,
// saturates to 16 bits and holds the finished result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsd_tpd import ctsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire ctsd_res_t   res_i,
  output ctsd_res_t        res_o,
  output      logic [15:0] tpd_o
);

  logic              sat;
  logic [DIV_IN_W-1:0] div_in;
  logic [PROD_W-1:0] prod;
  logic [15:0]       tpd_d;
  ctsd_res_t         res_q;
  logic [15:0]       tpd_q;

  // Below the saturation limit the period fits in 26 bits, so bits 25:4 are
  // the whole quotient input; the reciprocal is exact over that range.
  always_comb begin
    sat    = (res_i.cycle_period >= TPD_SAT_LIMIT);
    div_in = res_i.cycle_period[DIV_IN_W+3:4];
    prod   = PROD_W'(div_in) * PROD_W'(RECIP_M);
    tpd_d  = sat ? 16'hFFFF : prod[RECIP_SHIFT +: 16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_i;
      tpd_q <= tpd_d;
    end
  end

  assign res_o = res_q;
  assign tpd_o = tpd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/crank_tooth_sync_decoder_top.sv -----
// ----------------------------------------------------------------------------
// crank_tooth_sync_decoder_top
// Crank trigger wheel decoder, evenly spaced teeth plus a reference pulse.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_stall_o   kind, pin_high, edge_time,
//                                               timer_high, overflow_pending
//   out      output     out_valid_o/out_stall_i in_sync ... secondary_edges_seen
//   cfg      input      cfg_we_i                teeth_per_reference
//
// One edge beat is accepted per cycle while in_stall_o is low; its result is
// registered in stage one, then in the output register, with the period divide
// and its multiplier in between. Decoder state updates at acceptance. A stalled
// output holds its beat while the first stage can still take one.
// Reset clears all decoder state and sets the expected teeth to 12.
// ----------------------------------------------------------------------------
`default_nettype none

module crank_tooth_sync_decoder_top import ctsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        kind_i,
  input  wire logic        pin_high_i,
  input  wire logic [15:0] edge_time_i,
  input  wire logic [15:0] timer_high_i,
  input  wire logic        overflow_pending_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        in_sync_o,
  output      logic [7:0]  tooth_count_o,
  output      logic        sample_request_o,
  output      logic        sync_lost_o,
  output      logic        tooth_dropped_o,
  output      logic [31:0] cycle_period_o,
  output      logic [15:0] ticks_per_degree_o,
  output      logic [15:0] sync_loss_count_o,
  output      logic [15:0] dropped_count_o,
  output      logic [15:0] primary_edges_seen_o,
  output      logic [15:0] secondary_edges_seen_o
);

  logic      accept;
  logic      s1_valid_q, s1_valid_d;
  logic      s2_valid_q, s2_valid_d;
  logic      s2_en;
  ctsd_res_t core_res;
  ctsd_res_t s1_res_q;
  ctsd_res_t out_res;

  assign s2_en      = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_en;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s2_en) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_en) begin
      s2_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  ctsd_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .accept_i           (accept),
    .kind_i             (kind_i),
    .pin_high_i         (pin_high_i),
    .edge_time_i        (edge_time_i),
    .timer_high_i       (timer_high_i),
    .overflow_pending_i (overflow_pending_i),
    .res_o              (core_res)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= core_res;
    end
  end

  ctsd_tpd u_tpd (
    .clk_i (clk_i),
    .en_i  (s2_en),
    .res_i (s1_res_q),
    .res_o (out_res),
    .tpd_o (ticks_per_degree_o)
  );

  assign out_valid_o            = s2_valid_q;
  assign in_sync_o              = out_res.in_sync;
  assign tooth_count_o          = out_res.tooth_count;
  assign sample_request_o       = out_res.sample_request;
  assign sync_lost_o            = out_res.sync_lost;
  assign tooth_dropped_o        = out_res.tooth_dropped;
  assign cycle_period_o         = out_res.cycle_period;
  assign sync_loss_count_o      = out_res.sync_loss_count;
  assign dropped_count_o        = out_res.dropped_count;
  assign primary_edges_seen_o   = out_res.primary_edges_seen;
  assign secondary_edges_seen_o = out_res.secondary_edges_seen;

endmodule

`default_nettype wire

// ----- hw/rtl/ctsd_checker.sv -----
// ----------------------------------------------------------------------------
// ctsd_checker
// Port-level checks on the decoder's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crank_tooth_sync_decoder_top_macros.svh"

module ctsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        in_sync_o,
  input wire logic [7:0]  tooth_count_o,
  input wire logic        sample_request_o,
  input wire logic        sync_lost_o,
  input wire logic        tooth_dropped_o,
  input wire logic [31:0] cycle_period_o,
  input wire logic [15:0] ticks_per_degree_o
);

  // A dropped tooth happens only without sync and excludes the other events.
  `CTSD_ASSERT_NOW(a_drop_excl, out_valid_o && tooth_dropped_o, !in_sync_o && !sample_request_o && !sync_lost_o)

  // A sample request comes only with sync on a nonzero even count.
  `CTSD_ASSERT_NOW(a_sample_even, out_valid_o && sample_request_o, in_sync_o && !tooth_count_o[0] && (tooth_count_o != 8'd0))

  // A period shorter than one degree's worth gives zero ticks per degree.
  `CTSD_ASSERT_NOW(a_tpd_zero, out_valid_o && (cycle_period_o < 32'd720), ticks_per_degree_o == 16'd0)

  // A stalled beat stays presented with the same period.
  `CTSD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(cycle_period_o))

endmodule

bind crank_tooth_sync_decoder_top ctsd_checker u_ctsd_checker (.*);

`default_nettype wire

// ----- tb/sv/crank_tooth_sync_decoder_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crank_tooth_sync_decoder_top_test
// Self-checking test of the crank tooth sync decoder. Edge beats are driven
// through the valid/stall input channel while a local decoder model predicts
// every result beat; the output channel is stalled on its own pattern and
// each result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module crank_tooth_sync_decoder_top_test;
  import ctsd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASES = 5;

  typedef enum logic {
    TOOTH_EDGE     = 1'b0,
    REFERENCE_EDGE = 1'b1
  } edge_kind_e;

  localparam logic PIN_FALLING = 1'b0;
  localparam logic PIN_RISING  = 1'b1;

  typedef struct packed {
    logic        in_sync;
    logic [7:0]  tooth_count;
    logic        sample_request;
    logic        sync_lost;
    logic        tooth_dropped;
    logic [31:0] cycle_period;
    logic [15:0] ticks_per_degree;
    logic [15:0] sync_loss_count;
    logic [15:0] dropped_count;
    logic [15:0] primary_edges_seen;
    logic [15:0] secondary_edges_seen;
  } edge_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        kind_i;
  logic        pin_high_i;
  logic [15:0] edge_time_i;
  logic [15:0] timer_high_i;
  logic        overflow_pending_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        in_sync_o;
  logic [7:0]  tooth_count_o;
  logic        sample_request_o;
  logic        sync_lost_o;
  logic        tooth_dropped_o;
  logic [31:0] cycle_period_o;
  logic [15:0] ticks_per_degree_o;
  logic [15:0] sync_loss_count_o;
  logic [15:0] dropped_count_o;
  logic [15:0] primary_edges_seen_o;
  logic [15:0] secondary_edges_seen_o;

  // Decoder model state.
  logic [7:0]  model_teeth_per_ref;
  logic [7:0]  model_teeth;
  logic        model_synced;
  logic [31:0] model_ref_stamp;
  logic [31:0] model_period;
  logic [15:0] model_losses;
  logic [15:0] model_drops;
  logic [15:0] model_tooth_edges;
  logic [15:0] model_ref_edges;

  edge_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  edges_sent;
  int unsigned  burst_left;
  int unsigned  cycle_count;
  int unsigned  stall_tick;
  bit           gaps_on;
  logic [31:0]  wheel_time;

  crank_tooth_sync_decoder_top u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .kind_i                 (kind_i),
    .pin_high_i             (pin_high_i),
    .edge_time_i            (edge_time_i),
    .timer_high_i           (timer_high_i),
    .overflow_pending_i     (overflow_pending_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .in_sync_o              (in_sync_o),
    .tooth_count_o          (tooth_count_o),
    .sample_request_o       (sample_request_o),
    .sync_lost_o            (sync_lost_o),
    .tooth_dropped_o        (tooth_dropped_o),
    .cycle_period_o         (cycle_period_o),
    .ticks_per_degree_o     (ticks_per_degree_o),
    .sync_loss_count_o      (sync_loss_count_o),
    .dropped_count_o        (dropped_count_o),
    .primary_edges_seen_o   (primary_edges_seen_o),
    .secondary_edges_seen_o (secondary_edges_seen_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout at %0t with %0d results outstanding", $time, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver cycles through free-running, light, heavy and periodic stalls.
  always @(negedge clk_i) begin
    stall_tick++;
    case ((stall_tick / 97) % 4)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall_i <= ((stall_tick % 5) < 2);
      end
    endcase
  end

  function automatic edge_result_t decode_edge(edge_kind_e kind, logic rising,
                                               logic [15:0] etime, logic [15:0] thigh,
                                               logic ovf);
    edge_result_t r;
    logic [15:0]  stamp_hi;
    logic [31:0]  stamp;
    logic [31:0]  per_degree;
    r = '0;
    if (kind == TOOTH_EDGE) begin
      if (rising) begin
        if (model_teeth != TEETH_MAX) model_teeth++;
        if (!model_synced) begin
          model_drops++;
          r.tooth_dropped = 1'b1;
        end else if (model_teeth > model_teeth_per_ref) begin
          model_losses++;
          model_synced = 1'b0;
          model_teeth = '0;
          r.sync_lost = 1'b1;
        end else if (!model_teeth[0]) begin
          r.sample_request = 1'b1;
        end
      end
      model_tooth_edges++;
    end else begin
      if (rising) begin
        // The count is checked against the expected teeth before it clears.
        if (model_synced && model_teeth != model_teeth_per_ref) begin
          model_losses++;
          r.sync_lost = 1'b1;
        end
        model_teeth = '0;
        stamp_hi = thigh;
        if (ovf && !etime[HALF_BIT]) stamp_hi = thigh + 16'd1;
        stamp = {stamp_hi, etime};
        model_period = (stamp - model_ref_stamp) << 1;
        model_ref_stamp = stamp;
        model_synced = 1'b1;
      end
      model_ref_edges++;
    end
    per_degree = model_period / DEG_PER_CYCLE;
    r.in_sync              = model_synced;
    r.tooth_count          = model_teeth;
    r.cycle_period         = model_period;
    r.ticks_per_degree     = (per_degree > 32'hFFFF) ? 16'hFFFF : per_degree[15:0];
    r.sync_loss_count      = model_losses;
    r.dropped_count        = model_drops;
    r.primary_edges_seen   = model_tooth_edges;
    r.secondary_edges_seen = model_ref_edges;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    edge_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, actual tooth_count 0x%0h",
                 $time, tooth_count_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("in_sync", want.in_sync, in_sync_o);
        compare_field("tooth_count", want.tooth_count, tooth_count_o);
        compare_field("sample_request", want.sample_request, sample_request_o);
        compare_field("sync_lost", want.sync_lost, sync_lost_o);
        compare_field("tooth_dropped", want.tooth_dropped, tooth_dropped_o);
        compare_field("cycle_period", want.cycle_period, cycle_period_o);
        compare_field("ticks_per_degree", want.ticks_per_degree, ticks_per_degree_o);
        compare_field("sync_loss_count", want.sync_loss_count, sync_loss_count_o);
        compare_field("dropped_count", want.dropped_count, dropped_count_o);
        compare_field("primary_edges_seen", want.primary_edges_seen, primary_edges_seen_o);
        compare_field("secondary_edges_seen", want.secondary_edges_seen,
                      secondary_edges_seen_o);
      end
    end
  end

  // Sends one edge beat. Beats go out in bursts with random gaps between them while gaps_on is set.
  task automatic send_edge(edge_kind_e kind, logic rising, logic [15:0] etime,
                           logic [15:0] thigh, logic ovf);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    kind_i             <= kind;
    pin_high_i         <= rising;
    edge_time_i        <= etime;
    timer_high_i       <= thigh;
    overflow_pending_i <= ovf;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(decode_edge(kind, rising, etime, thigh, ovf));
    edges_sent++;
  endtask

  // Sends an edge at wheel_time. A capture in the lower half of the timer may
  // arrive before its overflow is counted, with the high word one behind.
  task automatic send_stamped(edge_kind_e kind, logic rising);
    if (!wheel_time[HALF_BIT] && $urandom_range(0, 3) == 0) begin
      send_edge(kind, rising, wheel_time[15:0], wheel_time[31:16] - 16'd1, 1'b1);
    end else begin
      send_edge(kind, rising, wheel_time[15:0], wheel_time[31:16],
                wheel_time[HALF_BIT] ? 1'($urandom_range(0, 1)) : 1'b0);
    end
  endtask

  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_teeth(logic [7:0] teeth);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= teeth;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    model_teeth_per_ref = teeth;
  endtask

  // One turn of the wheel: a reference pulse followed by the teeth, each
  // rising edge possibly followed by its falling edge.
  task automatic run_revolution(int teeth, int slip, int unsigned tooth_gap);
    int count;
    count = teeth + slip;
    if (count < 0) count = 0;
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    if ($urandom_range(0, 3) == 0) send_stamped(REFERENCE_EDGE, PIN_FALLING);
    for (int i = 0; i < count; i++) begin
      wheel_time += tooth_gap;
      send_stamped(TOOTH_EDGE, PIN_RISING);
      if ($urandom_range(0, 1) != 0) send_stamped(TOOTH_EDGE, PIN_FALLING);
    end
    wheel_time += tooth_gap;
  endtask

  task automatic test_sync_acquire();
    send_edge(TOOTH_EDGE, PIN_RISING, 16'h0000, 16'h0000, 1'b0);
    send_edge(TOOTH_EDGE, PIN_FALLING, 16'hFFFF, 16'hFFFF, 1'b1);
    send_edge(REFERENCE_EDGE, PIN_FALLING, 16'hFFFF, 16'hFFFF, 1'b1);
    send_edge(REFERENCE_EDGE, PIN_RISING, 16'h1000, 16'h0000, 1'b0);
    for (int i = 1; i <= int'(TEETH_RESET); i++) begin
      send_edge(TOOTH_EDGE, PIN_RISING, 16'(16'h1000 + i * 16'h0100), 16'h0000, 1'b0);
    end
    send_edge(REFERENCE_EDGE, PIN_RISING, 16'h2000, 16'h0000, 1'b0);
  endtask

  task automatic test_timestamp_word();
    // A pending overflow bumps the high word only for a lower-half capture.
    send_edge(REFERENCE_EDGE, PIN_RISING, 16'h7FFF, 16'hFFFF, 1'b1);
    send_edge(REFERENCE_EDGE, PIN_RISING, 16'h8000, 16'h1234, 1'b1);
    send_edge(REFERENCE_EDGE, PIN_RISING, 16'h0000, 16'h1234, 1'b1);
    send_edge(REFERENCE_EDGE, PIN_RISING, 16'hFFFF, 16'hFFFF, 1'b0);
  endtask

  task automatic test_period_extremes();
    // The previous reference sits at the top of the timer, so this one wraps.
    wheel_time = 32'h0000_0010;
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    // Just at the saturation point of ticks per degree, then just below it.
    wheel_time += 32'd23592960;
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    wheel_time += 32'd23592959;
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    // The doubled interval overflows 32 bits.
    wheel_time += 32'h9000_0000;
    send_stamped(REFERENCE_EDGE, PIN_RISING);
  endtask

  task automatic test_zero_teeth();
    write_teeth(8'd0);
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    send_stamped(TOOTH_EDGE, PIN_RISING);
    send_stamped(TOOTH_EDGE, PIN_RISING);
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    send_stamped(REFERENCE_EDGE, PIN_RISING);
  endtask

  task automatic test_loss_on_reference();
    write_teeth(8'd3);
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    send_stamped(TOOTH_EDGE, PIN_RISING);
    send_stamped(TOOTH_EDGE, PIN_RISING);
    // Too few teeth: sync is lost and regained on the same beat.
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    repeat (4) send_stamped(TOOTH_EDGE, PIN_RISING);
  endtask

  task automatic test_count_saturation();
    write_teeth(TEETH_MAX);
    repeat (258) begin
      wheel_time += $urandom_range(1, 500);
      send_stamped(TOOTH_EDGE, PIN_RISING);
    end
    send_stamped(REFERENCE_EDGE, PIN_RISING);
    send_stamped(TOOTH_EDGE, PIN_RISING);
  endtask

  task automatic test_random_wheel();
    logic [7:0]  settings [PHASES];
    int unsigned budgets [PHASES];
    int unsigned phase_start;
    int unsigned pick;
    int          slip;
    settings = '{8'd1, TEETH_MAX, TEETH_RESET, 8'($urandom_range(2, 40)),
                 8'($urandom_range(1, 8))};
    budgets  = '{100, 100, 150, 150, 100};
    for (int p = 0; p < PHASES; p++) begin
      write_teeth(settings[p]);
      gaps_on = (p != 2);
      phase_start = edges_sent;
      while (edges_sent - phase_start < budgets[p]) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          slip = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4)) - 2 : 0;
          run_revolution(settings[p], slip, $urandom_range(1, 3000));
        end else if (pick < 82) begin
          send_edge($urandom_range(0, 1) ? REFERENCE_EDGE : TOOTH_EDGE,
                    1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)));
        end else if (pick < 90) begin
          // Long pause of the engine: large or wrapped periods follow.
          wheel_time += $urandom;
        end else if (pick < 96) begin
          repeat ($urandom_range(1, 6)) send_stamped(TOOTH_EDGE, PIN_RISING);
        end else begin
          drain();
        end
      end
    end
  endtask

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    kind_i             = TOOTH_EDGE;
    pin_high_i         = PIN_FALLING;
    edge_time_i        = '0;
    timer_high_i       = '0;
    overflow_pending_i = 1'b0;
    out_stall_i        = 1'b0;

    model_teeth_per_ref = TEETH_RESET;
    model_teeth         = '0;
    model_synced        = 1'b0;
    model_ref_stamp     = '0;
    model_period        = '0;
    model_losses        = '0;
    model_drops         = '0;
    model_tooth_edges   = '0;
    model_ref_edges     = '0;
    mismatches          = 0;
    edges_sent          = 0;
    burst_left          = 0;
    cycle_count         = 0;
    stall_tick          = 0;
    gaps_on             = 1'b1;
    wheel_time          = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_sync_acquire();
    test_timestamp_word();
    test_period_extremes();
    test_zero_teeth();
    test_loss_on_reference();
    test_count_saturation();
    test_random_wheel();
    drain();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
